/* rtl/gbl_pkg.sv */
package gbl_pkg;

   // grid geometry
   localparam int POSTS_PER_DEGREE = 1;
   localparam int ANGLE_FRAC_BITS  = 16;
   localparam longint ONE_DEG      = 64'sd1 <<< ANGLE_FRAC_BITS;
   localparam int GRID_ROWS        = 180 * POSTS_PER_DEGREE + 1;
   localparam int GRID_COLS        = 360 * POSTS_PER_DEGREE;
   localparam int GRID_DEPTH       = GRID_ROWS * GRID_COLS;

   // four banks by row parity and column parity
   localparam int HALF_ROWS  = (GRID_ROWS + 1) / 2;
   localparam int HALF_COLS  = GRID_COLS / 2;
   localparam int BANK_DEPTH = HALF_ROWS * HALF_COLS;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   localparam int ROW_W  = $clog2(GRID_ROWS);
   localparam int COL_W  = $clog2(GRID_COLS + 1);
   localparam int FRAC_W = ANGLE_FRAC_BITS;
   localparam int ANG_W  = ANGLE_FRAC_BITS + 12;
   localparam int POST_W = 24;

   // row = index / GRID_COLS by reciprocal multiply
   localparam int DIV_SHIFT = 25;
   localparam int DIV_MUL   = (2 ** DIV_SHIFT + GRID_COLS - 1) / GRID_COLS;
   localparam int DIV_MW    = $clog2(DIV_MUL + 1);

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   // one classified operation between front and back
   typedef struct packed {
      logic                           is_write;
      logic [1:0]                     wbank;
      logic [BANK_AW-1:0]             waddr;
      logic signed [POST_W-1:0]       wdata;
      logic [3:0][BANK_AW-1:0]        raddr;
      logic                           nw_rp;
      logic                           nw_cp;
      logic [FRAC_W-1:0]              nx;
      logic [FRAC_W-1:0]              ny;
   } op_type;

endpackage

/* rtl/gbl_front.sv */
module gbl_front import gbl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  mode_type                 mode,
   input  logic [15:0]              post_index,
   input  logic signed [23:0]       post_value,
   input  logic signed [23:0]       latitude,
   input  logic signed [24:0]       longitude,
   output logic                     op_valid,
   input  logic                     op_ready,
   output op_type                   op
);

   localparam logic signed [ANG_W-1:0] LAT_HI = ANG_W'(90 * ONE_DEG);
   localparam logic signed [ANG_W-1:0] LAT_LO = ANG_W'(-90 * ONE_DEG + 1);
   localparam logic signed [ANG_W-1:0] LON_HI = ANG_W'(180 * ONE_DEG);
   localparam logic signed [ANG_W-1:0] LON_LO = ANG_W'(-180 * ONE_DEG + 1);
   localparam logic signed [ANG_W-1:0] PPD_S  = ANG_W'(POSTS_PER_DEGREE);

   logic                      s1_v_ff, s1_v_in;
   logic                      s1_wr_ff;
   logic [ROW_W-1:0]          s1_row_ff, s1_row_in;
   logic [COL_W-1:0]          s1_col_ff, s1_col_in;
   logic [15:0]               s1_idx_ff;
   logic signed [POST_W-1:0]  s1_data_ff;
   logic [FRAC_W-1:0]         s1_nx_ff, s1_ny_ff, nx_in, ny_in;
   logic                      s2_v_ff;
   op_type                    s2_op_ff, s2_op_in;
   logic                      s1_ready, s2_ready;

   logic signed [ANG_W-1:0]   lat_x, lon_x, latc, lonc, dy, dx;
   logic [ROW_W-1:0]          qrow;
   logic [16+DIV_MW-1:0]      prod;
   logic                      in_range;

   logic [COL_W-1:0]          wcol, col, col_e;
   logic [ROW_W-1:0]          rhalf0, rhalf1;
   logic [COL_W-1:0]          chalf0, chalf1;

   assign s2_ready = !s2_v_ff || op_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: clamp angles, floor to grid, row of a write address
   always_comb begin
      lat_x = ANG_W'(latitude);
      lon_x = ANG_W'(longitude);
      latc  = (lat_x < LAT_LO) ? LAT_LO : ((lat_x > LAT_HI) ? LAT_HI : lat_x);
      lonc  = (lon_x < LON_LO) ? LON_LO : ((lon_x > LON_HI) ? LON_HI : lon_x);
      dy    = (LAT_HI - latc) * PPD_S;
      dx    = (lonc + LON_HI) * PPD_S;
      qrow  = dy[FRAC_W +: ROW_W];
      if (qrow >= ROW_W'(GRID_ROWS - 1)) begin
         qrow = ROW_W'(GRID_ROWS - 2);
      end
      nx_in    = dx[FRAC_W-1:0];
      ny_in    = dy[FRAC_W-1:0];
      prod     = (16 + DIV_MW)'(post_index) * (16 + DIV_MW)'(DIV_MUL);
      in_range = 32'(post_index) < 32'(GRID_DEPTH);
      s1_v_in  = in_valid && ((mode == MODE_QUERY) || in_range);
      s1_row_in = (mode == MODE_WRITE) ? prod[DIV_SHIFT +: ROW_W] : qrow;
      s1_col_in = dx[FRAC_W +: COL_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_v_ff <= s1_v_in;
      end
      if (s1_ready) begin
         s1_wr_ff   <= (mode == MODE_WRITE);
         s1_row_ff  <= s1_row_in;
         s1_col_ff  <= s1_col_in;
         s1_idx_ff  <= post_index;
         s1_data_ff <= post_value;
         s1_nx_ff   <= nx_in;
         s1_ny_ff   <= ny_in;
      end
   end

   // stage 2: bank addresses
   always_comb begin
      wcol  = COL_W'(32'(s1_idx_ff) - 32'(s1_row_ff) * GRID_COLS);
      col   = (s1_col_ff >= COL_W'(GRID_COLS)) ? s1_col_ff - COL_W'(GRID_COLS) : s1_col_ff;
      col_e = (col == COL_W'(GRID_COLS - 1)) ? '0 : col + 1'b1;
      rhalf0 = ROW_W'((32'(s1_row_ff) + 1) >> 1);
      rhalf1 = s1_row_ff >> 1;
      chalf1 = col >> 1;
      chalf0 = col[0] ? (col_e >> 1) : (col >> 1);

      s2_op_in          = '0;
      s2_op_in.is_write = s1_wr_ff;
      s2_op_in.wbank    = {s1_row_ff[0], wcol[0]};
      s2_op_in.waddr    = BANK_AW'(32'(s1_row_ff >> 1) * HALF_COLS + 32'(wcol >> 1));
      s2_op_in.wdata    = s1_data_ff;
      s2_op_in.raddr[0] = BANK_AW'(32'(rhalf0) * HALF_COLS + 32'(chalf0));
      s2_op_in.raddr[1] = BANK_AW'(32'(rhalf0) * HALF_COLS + 32'(chalf1));
      s2_op_in.raddr[2] = BANK_AW'(32'(rhalf1) * HALF_COLS + 32'(chalf0));
      s2_op_in.raddr[3] = BANK_AW'(32'(rhalf1) * HALF_COLS + 32'(chalf1));
      s2_op_in.nw_rp    = s1_row_ff[0];
      s2_op_in.nw_cp    = col[0];
      s2_op_in.nx       = s1_nx_ff;
      s2_op_in.ny       = s1_ny_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_v_ff <= s1_v_ff;
      end
      if (s2_ready) begin
         s2_op_ff <= s2_op_in;
      end
   end

   assign op_valid = s2_v_ff;
   assign op       = s2_op_ff;

endmodule

/* rtl/gbl_queue.sv */
module gbl_queue import gbl_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  op_type in_op,
   output logic   out_valid,
   input  logic   out_ready,
   output op_type out_op
);

   localparam int Q_DEPTH = 4;

   op_type              mem_ff [Q_DEPTH];
   logic [1:0]          wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready  = cnt_ff < 3'(Q_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_op    = mem_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count
   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         mem_ff[wptr_ff] <= in_op;
      end
   end

endmodule

/* rtl/gbl_back.sv */
module gbl_back import gbl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_valid,
   output logic                     op_ready,
   input  op_type                   op,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [POST_W-1:0]        out_height
);

   localparam int OUT_DEPTH = 8;

   // grid banks, index {row parity, column parity}
   logic [POST_W-1:0]         bank_mem [4][BANK_DEPTH];
   logic [3:0][POST_W-1:0]    rd_ff;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                      rp_ff, cp_ff;
   logic [FRAC_W-1:0]         nx1_ff, ny1_ff, nx2_ff, ny2_ff, ny3_ff, ny4_ff;
   logic signed [POST_W:0]    dt_ff, db_ff, dt_in, db_in;
   logic signed [POST_W-1:0]  nw2_ff, sw2_ff, nw3_ff, sw3_ff, nw, ne, sw, se;
   logic signed [41:0]        pt_ff, pb_ff, tt, tb;
   logic signed [25:0]        qt4_ff, qt5_ff, qt_t, qt_b;
   logic [FRAC_W-1:0]         rt4_ff, rt5_ff;
   logic signed [26:0]        dq_ff;
   logic signed [FRAC_W:0]    dr_ff;
   logic signed [43:0]        m1_ff;
   logic signed [33:0]        m2_ff;
   logic signed [61:0]        acc;
   logic signed [29:0]        h_full;

   logic [POST_W-1:0]         ofifo_ff [OUT_DEPTH];
   logic [2:0]                wptr_ff, rptr_ff;
   logic [3:0]                cnt_ff, cnt_in;
   logic [2:0]                inflight;
   logic                      credit_ok, pop, out_pop, push;

   // issue only when the result has a guaranteed slot in the output fifo
   assign inflight  = 3'($countones({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff}));
   assign credit_ok = (4'(inflight) + cnt_ff) < 4'(OUT_DEPTH);
   assign pop       = op_valid && (op.is_write || credit_ok);
   assign op_ready  = pop;

   // bank write and four parallel reads
   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (pop && op.is_write && (op.wbank == 2'(b))) begin
            bank_mem[b][op.waddr] <= op.wdata;
         end
         rd_ff[b] <= bank_mem[b][op.raddr[b]];
      end
      rp_ff  <= op.nw_rp;
      cp_ff  <= op.nw_cp;
      nx1_ff <= op.nx;
      ny1_ff <= op.ny;
   end

   // pick corners, horizontal differences
   always_comb begin
      nw    = rd_ff[{rp_ff, cp_ff}];
      ne    = rd_ff[{rp_ff, ~cp_ff}];
      sw    = rd_ff[{~rp_ff, cp_ff}];
      se    = rd_ff[{~rp_ff, ~cp_ff}];
      dt_in = (POST_W+1)'(ne) - (POST_W+1)'(nw);
      db_in = (POST_W+1)'(se) - (POST_W+1)'(sw);
   end

   // top/bottom blends split into quotient and fraction, and the final vertical blend
   always_comb begin
      tt   = (42'(nw3_ff) <<< FRAC_W) + pt_ff;
      tb   = (42'(sw3_ff) <<< FRAC_W) + pb_ff;
      qt_t = tt[FRAC_W +: 26];
      qt_b = tb[FRAC_W +: 26];
      acc  = ((62'(m1_ff) + 62'($signed({1'b0, rt5_ff}))) <<< FRAC_W) + 62'(m2_ff);
      h_full = 30'(qt5_ff) + acc[61:2*FRAC_W];
   end

   always_ff @(posedge clock) begin
      dt_ff  <= dt_in;
      db_ff  <= db_in;
      nw2_ff <= nw;
      sw2_ff <= sw;
      nx2_ff <= nx1_ff;
      ny2_ff <= ny1_ff;

      pt_ff  <= dt_ff * $signed({1'b0, nx2_ff});
      pb_ff  <= db_ff * $signed({1'b0, nx2_ff});
      nw3_ff <= nw2_ff;
      sw3_ff <= sw2_ff;
      ny3_ff <= ny2_ff;

      qt4_ff <= qt_t;
      rt4_ff <= tt[FRAC_W-1:0];
      dq_ff  <= 27'(qt_b) - 27'(qt_t);
      dr_ff  <= $signed({1'b0, tb[FRAC_W-1:0]}) - $signed({1'b0, tt[FRAC_W-1:0]});
      ny4_ff <= ny3_ff;

      m1_ff  <= dq_ff * $signed({1'b0, ny4_ff});
      m2_ff  <= dr_ff * $signed({1'b0, ny4_ff});
      qt5_ff <= qt4_ff;
      rt5_ff <= rt4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= pop && !op.is_write;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // output fifo, isolates result stalls from the pipe
   assign push       = v5_ff;
   assign out_valid  = cnt_ff != '0;
   assign out_pop    = out_valid && out_ready;
   assign out_height = ofifo_ff[rptr_ff];
   assign cnt_in     = cnt_ff + 4'(push) - 4'(out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (out_pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
      if (push) begin
         ofifo_ff[wptr_ff] <= h_full[POST_W-1:0];
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !out_pop && (cnt_ff == 4'(OUT_DEPTH))))
      else $error("output fifo overflow");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (4'(inflight) + cnt_ff) <= 4'(OUT_DEPTH))
      else $error("in-flight results exceed output space");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (pop && op.is_write) |=> !v1_ff)
      else $error("post write entered the blend pipe");

endmodule

/* rtl/geoid_grid_bilinear_lookup_core.sv */
// Global height grid (181 x 360 posts at one post per degree) with bilinear
// lookup. A request with mode 0 stores one post; mode 1 returns one height
// blended from the four surrounding posts, floored to 1/1024 m. One request
// is taken per clock when the output side keeps up: the grid is split into
// four banks by row and column parity, so all four corner posts are read in
// the same cycle. With no stalls, a query response passes through two address
// stages, the queue, the memory read, four blend stages and the output fifo.
// Grid content is undefined after reset; only query posts that were written.
module geoid_grid_bilinear_lookup_core import gbl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // post_index[15:0], post_value[39:16], latitude[63:40], longitude[88:64]
   input  logic [95:0] req_tdata,
   // mode[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // height[23:0]
   output logic [23:0] rsp_tdata
);

   logic   f_valid, f_ready, q_valid, q_ready;
   op_type f_op, q_op;

   gbl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .mode       (mode_type'(req_tuser[0])),
      .post_index (req_tdata[15:0]),
      .post_value (req_tdata[39:16]),
      .latitude   (req_tdata[63:40]),
      .longitude  (req_tdata[88:64]),
      .op_valid   (f_valid),
      .op_ready   (f_ready),
      .op         (f_op)
   );

   gbl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_op     (f_op),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_op    (q_op)
   );

   gbl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (q_valid),
      .op_ready   (q_ready),
      .op         (q_op),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_height (rsp_tdata)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import gbl_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;

   // shared pacing controls
   bit steady   = 0;
   bit hold_go  = 0;
   int hold_cnt = 0;

   // mirror of the post grid plus queue of expected heights
   class height_board;
      int  posts   [GRID_DEPTH];
      bit  written [GRID_DEPTH];
      logic [23:0] heights [$];
      int  errors = 0;

      task report(string msg);
         $display("ERROR %0t: %s", $realtime, msg);
         errors++;
      endtask

      // clamp, floor to the north-west post, edge fixes
      function void locate(logic signed [23:0] lat, logic signed [24:0] lon,
                           output int corner[4], output longint fx, output longint fy);
         longint la, lo, dy, dx, row, col, cole;
         la = longint'(lat);
         lo = longint'(lon);
         if (la < -90 * ONE_DEG + 1) la = -90 * ONE_DEG + 1;
         if (la > 90 * ONE_DEG) la = 90 * ONE_DEG;
         if (lo < -180 * ONE_DEG + 1) lo = -180 * ONE_DEG + 1;
         if (lo > 180 * ONE_DEG) lo = 180 * ONE_DEG;
         dy = (90 * ONE_DEG - la) * POSTS_PER_DEGREE;
         dx = (lo + 180 * ONE_DEG) * POSTS_PER_DEGREE;
         row = dy >>> ANGLE_FRAC_BITS;
         col = dx >>> ANGLE_FRAC_BITS;
         fy = dy & (ONE_DEG - 1);
         fx = dx & (ONE_DEG - 1);
         if (row >= GRID_ROWS - 1) row = GRID_ROWS - 2;
         if (col >= GRID_COLS) col -= GRID_COLS;
         cole = (col + 1 >= GRID_COLS) ? 0 : col + 1;
         corner[0] = int'(row * GRID_COLS + col);
         corner[1] = int'(row * GRID_COLS + cole);
         corner[2] = int'((row + 1) * GRID_COLS + col);
         corner[3] = int'((row + 1) * GRID_COLS + cole);
      endfunction

      function void note_request(mode_type mode, logic [15:0] idx,
                                 logic signed [23:0] val,
                                 logic signed [23:0] lat, logic signed [24:0] lon);
         int corner[4];
         longint fx, fy, acc;
         if (mode == MODE_WRITE) begin
            if (idx < GRID_DEPTH) begin
               posts[idx]   = int'(val);
               written[idx] = 1;
            end
            return;
         end
         locate(lat, lon, corner, fx, fy);
         // exact blend over 2^(2F), floored by arithmetic shift
         acc = longint'(posts[corner[0]]) * (ONE_DEG - fx) * (ONE_DEG - fy)
             + longint'(posts[corner[1]]) * fx * (ONE_DEG - fy)
             + longint'(posts[corner[2]]) * (ONE_DEG - fx) * fy
             + longint'(posts[corner[3]]) * fx * fy;
         acc = acc >>> (2 * ANGLE_FRAC_BITS);
         heights.push_back(acc[23:0]);
      endfunction

      task check_height(logic [23:0] got);
         logic [23:0] want;
         if (heights.size() == 0) begin
            report($sformatf("unexpected response height=%h", got));
            return;
         end
         want = heights.pop_front();
         if (got !== want)
            report($sformatf("height got %h want %h", got, want));
      endtask
   endclass

   height_board board;

   geoid_grid_bilinear_lookup_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 12 ns clock
   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // response side: random stalls, a quiet stretch and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_go && hold_cnt < 300) begin
         rsp_tready <= 0;
         hold_cnt++;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 20);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_height(rsp_tdata);
   end

   // offer one request and wait for it to be taken
   task send(mode_type mode, logic [15:0] idx, logic signed [23:0] val,
             logic signed [23:0] lat, logic signed [24:0] lon);
      if (!steady && $urandom_range(99) < 20) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= mode;
      req_tdata  <= {7'b0, lon, lat, val, idx};
      do @(posedge clock); while (!req_tready);
      board.note_request(mode, idx, val, lat, lon);
   endtask

   task write_post(logic [15:0] idx, logic signed [23:0] val);
      send(MODE_WRITE, idx, val, 24'($urandom), 25'($urandom));
   endtask

   // query; any corner never stored gets a random post first
   task query(logic signed [23:0] lat, logic signed [24:0] lon);
      int corner[4];
      longint fx, fy;
      board.locate(lat, lon, corner, fx, fy);
      foreach (corner[k])
         if (!board.written[corner[k]])
            write_post(16'(corner[k]), 24'($urandom));
      send(MODE_QUERY, 16'($urandom), 24'($urandom), lat, lon);
   endtask

   function logic signed [23:0] pick_lat();
      if ($urandom_range(9) < 2) return 24'($urandom);
      return 24'($urandom_range(2 * 5898240) - 5898240);
   endfunction

   function logic signed [24:0] pick_lon();
      if ($urandom_range(9) < 2) return 25'($urandom);
      return 25'($urandom_range(2 * 11796480) - 11796480);
   endfunction

   // stimulus
   initial begin
      int sel;
      board = new();
      reset      = 1;
      req_tvalid = 0;
      req_tuser  = '0;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // extremes: poles, date line wrap, clamps, index edges
      write_post(16'd0, 24'sh7FFFFF);
      write_post(16'd1, 24'sh800000);
      write_post(16'(GRID_DEPTH - 1), 24'sh800000);
      write_post(16'(GRID_DEPTH), 24'sh123456);
      write_post(16'hFFFF, 24'sh654321);
      write_post(16'(GRID_COLS - 1), 24'sh7FFFFF);
      query(24'sd5898240, -25'sd11796480);
      query(24'sh7FFFFF, 25'sh0FFFFFF);
      query(-24'sd5898240, 25'sd11796480);
      query(-24'sd5898239, -25'sd11796479);
      query(24'sh800000, 25'sh1000000);
      query(24'sd0, 25'sd11796479);
      query(24'sd5898239, 25'sd11796415);
      query(24'sd5865472, -25'sd11763712);
      query(-24'sd5865473, 25'sd0);
      query(24'sd32768, 25'sd32768);

      // random mix of queries, overwrites and stray writes; a fresh query
      // usually brings up to four post writes with it
      for (int n = 0; n < 240; n++) begin
         steady = (n >= 80 && n < 130);
         if (n == 150) hold_go = 1;
         sel = $urandom_range(99);
         if (sel < 60)
            query(pick_lat(), pick_lon());
         else if (sel < 90)
            write_post(16'($urandom_range(GRID_DEPTH - 1)), 24'($urandom));
         else
            write_post(16'($urandom_range(16'hFFFF, GRID_DEPTH)), 24'($urandom));
      end
      req_tvalid <= 0;
      steady = 0;

      while (board.heights.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // run limit
   initial begin
      #3000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
